// ----- rtl/ept_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder period tracker package
// Shared types and constants for the encoder period and distance tracker.
// ----------------------------------------------------------------------------
package ept_pkg;

    typedef enum logic [1:0] {
        OP_CAPTURE      = 2'd0,
        OP_QUERY        = 2'd1,
        OP_SET_DISTANCE = 2'd2
    } op_t;

    localparam logic [31:0] PERIOD_NONE = 32'hFFFF_FFFF;
    localparam logic [9:0]  VPM_RESET   = 10'd100;

    // Distance scaling divides by 100 as a shift by two, then a division by 25
    // done as a multiplication by a rounded-up reciprocal. The reciprocal is
    // exact for every dividend below 2^24.
    localparam int          PRODUCT_W   = 26;
    localparam int          QUOT_IN_W   = 24;
    localparam int          RECIP_W     = 25;
    localparam logic [24:0] RECIP_25    = 25'd21474837;
    localparam int          RECIP_SHIFT = 29;
    localparam int          SETPOINT_W  = 20;

    typedef struct packed {
        op_t                   op;
        logic [15:0]           capture_time;
        logic [31:0]           overflow_count;
        logic [SETPOINT_W-1:0] setpoint;
    } ch_cmd_t;

    typedef struct packed {
        logic [31:0] period;
        logic [15:0] edge_count;
        logic        stop_motor;
    } ch_result_t;

endpackage

// ----- rtl/ept_item_if.sv -----
// ----------------------------------------------------------------------------
// Encoder tracker item channel
// Valid/ready channel carrying one command item into the tracker.
// ----------------------------------------------------------------------------
interface ept_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        channel;
    logic [15:0] capture_time;
    logic [31:0] overflow_count;
    logic [15:0] distance_cm;

    modport source (
        output valid, operation, channel, capture_time, overflow_count, distance_cm,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, capture_time, overflow_count, distance_cm,
        output ready
    );
endinterface

// ----- rtl/ept_result_if.sv -----
// ----------------------------------------------------------------------------
// Encoder tracker result channel
// Valid/ready channel carrying one result item out of the tracker.
// ----------------------------------------------------------------------------
interface ept_result_if;
    logic        valid;
    logic        ready;
    logic        channel_out;
    logic [31:0] period;
    logic [15:0] edge_count;
    logic        stop_motor;

    modport source (
        output valid, channel_out, period, edge_count, stop_motor,
        input  ready
    );
    modport sink (
        input  valid, channel_out, period, edge_count, stop_motor,
        output ready
    );
endinterface

// ----- rtl/ept_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Encoder tracker configuration channel
// Valid/ready write channel for the vanes-per-metre register.
// ----------------------------------------------------------------------------
interface ept_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] vanes_per_metre;

    modport source (
        output valid, vanes_per_metre,
        input  ready
    );
    modport sink (
        input  valid, vanes_per_metre,
        output ready
    );
endinterface

// ----- rtl/ept_channel.sv -----
// ----------------------------------------------------------------------------
// Encoder tracker channel
// State of one encoder channel, its capture, query and setpoint updates.
// ----------------------------------------------------------------------------
module ept_channel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  ept_pkg::ch_cmd_t     cmd,
    output ept_pkg::ch_result_t  res
);

    logic [15:0] edges_reg,    edges_next;
    logic [15:0] interval_reg, interval_next;
    logic [15:0] prev_reg,     prev_next;
    logic        fresh_reg,    fresh_next;
    logic [31:0] mark_reg,     mark_next;
    logic [31:0] vanes_reg,    vanes_next;

    logic        have_edges;
    logic [31:0] ovf_diff;
    logic [31:0] ovf_ext;
    logic [31:0] period_sum;

    // Multiplying by 0xFFFF is a shift by 16 less the value itself.
    assign have_edges = (edges_reg != 16'd0);
    assign ovf_diff   = cmd.overflow_count - mark_reg;
    assign ovf_ext    = {ovf_diff[15:0], 16'd0} - ovf_diff;
    assign period_sum = {16'd0, interval_reg} + ovf_ext;

    always_comb
    begin
        edges_next     = edges_reg;
        interval_next  = interval_reg;
        prev_next      = prev_reg;
        fresh_next     = fresh_reg;
        mark_next      = mark_reg;
        vanes_next     = vanes_reg;
        res.period     = 32'd0;
        res.edge_count = edges_reg;
        res.stop_motor = 1'b0;
        case (cmd.op)
            ept_pkg::OP_CAPTURE:
            begin
                if (vanes_reg != 32'd0)
                begin
                    vanes_next     = vanes_reg - 32'd1;
                    res.stop_motor = (vanes_reg == 32'd1);
                end
                interval_next  = cmd.capture_time - prev_reg;
                edges_next     = edges_reg + 16'd1;
                prev_next      = cmd.capture_time;
                fresh_next     = 1'b1;
                res.edge_count = edges_reg + 16'd1;
            end
            ept_pkg::OP_QUERY:
            begin
                if (!have_edges || period_sum == 32'd0)
                begin
                    res.period = ept_pkg::PERIOD_NONE;
                end
                else
                begin
                    res.period = period_sum;
                end
                if (have_edges && fresh_reg)
                begin
                    mark_next  = cmd.overflow_count;
                    fresh_next = 1'b0;
                end
            end
            ept_pkg::OP_SET_DISTANCE:
            begin
                vanes_next = {{(32 - ept_pkg::SETPOINT_W){1'b0}}, cmd.setpoint};
            end
            default:
            begin
                edges_next = edges_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg    <= 16'd0;
            interval_reg <= 16'd0;
            prev_reg     <= 16'd0;
            fresh_reg    <= 1'b0;
            mark_reg     <= 32'd0;
            vanes_reg    <= 32'd0;
        end
        else if (update)
        begin
            edges_reg    <= edges_next;
            interval_reg <= interval_next;
            prev_reg     <= prev_next;
            fresh_reg    <= fresh_next;
            mark_reg     <= mark_next;
            vanes_reg    <= vanes_next;
        end
    end

endmodule

// ----- rtl/encoder_period_distance_tracker.sv -----
// Pipeline: an accepted item goes to the input register, then the result register.
// Throughput: one item per cycle unless the result side stalls; an item may
// follow on the same channel in the next cycle, since channel state is
// updated as the result is registered.
// Reset: rst_n clears all channel state and both valid flags, and loads
// vanes_per_metre with 100. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Encoder period and distance tracker
// Captures encoder edges, reports extended periods and counts down setpoints.
// ----------------------------------------------------------------------------
module encoder_period_distance_tracker #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    ept_cfg_if.sink      cfg,
    ept_item_if.sink     item,
    ept_result_if.source result
);

    logic [9:0] vpm_reg;

    // Input register
    logic                         in_valid_reg;
    ept_pkg::op_t                 op_reg;
    logic                         channel_reg;
    logic [15:0]                  capture_reg;
    logic [31:0]                  overflow_reg;
    logic [ept_pkg::PRODUCT_W-1:0] product_reg;

    // Result register
    logic        out_valid_reg;
    logic        channel_out_reg;
    logic [31:0] period_reg;
    logic [15:0] edge_count_reg;
    logic        stop_motor_reg;

    logic                                         advance;
    logic                                         in_ready;
    logic [ept_pkg::PRODUCT_W-1:0]                product_next;
    logic [ept_pkg::QUOT_IN_W+ept_pkg::RECIP_W-1:0] scaled;
    ept_pkg::ch_cmd_t                             cmd;
    ept_pkg::ch_result_t                          ch_res [NUM_CHANNELS];
    ept_pkg::ch_result_t                          sel_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpm_reg <= ept_pkg::VPM_RESET;
        end
        else if (cfg.valid)
        begin
            vpm_reg <= cfg.vanes_per_metre;
        end
    end

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign in_ready   = !in_valid_reg || advance;
    assign item.ready = in_ready;

    // Distance times vanes per metre is formed ahead of the input register.
    assign product_next = {10'd0, item.distance_cm} * {16'd0, vpm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && item.valid)
        begin
            op_reg       <= ept_pkg::op_t'(item.operation);
            channel_reg  <= item.channel;
            capture_reg  <= item.capture_time;
            overflow_reg <= item.overflow_count;
            product_reg  <= product_next;
        end
    end

    // Division by 100: drop two bits, then divide by 25 by reciprocal.
    assign scaled = product_reg[ept_pkg::PRODUCT_W-1:2] * ept_pkg::RECIP_25;

    always_comb
    begin
        cmd.op             = op_reg;
        cmd.capture_time   = capture_reg;
        cmd.overflow_count = overflow_reg;
        cmd.setpoint       =
            scaled[ept_pkg::RECIP_SHIFT +: ept_pkg::SETPOINT_W];
    end

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_channel
        ept_channel u_channel (
            .clk    (clk),
            .rst_n  (rst_n),
            .update (advance && (32'(channel_reg) == i)),
            .cmd    (cmd),
            .res    (ch_res[i])
        );
    end

    // A channel with no slot reads as all zeros and changes nothing.
    always_comb
    begin
        sel_res = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (32'(channel_reg) == i)
            begin
                sel_res = ch_res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            channel_out_reg <= channel_reg;
            period_reg      <= sel_res.period;
            edge_count_reg  <= sel_res.edge_count;
            stop_motor_reg  <= sel_res.stop_motor;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.channel_out = channel_out_reg;
    assign result.period      = period_reg;
    assign result.edge_count  = edge_count_reg;
    assign result.stop_motor  = stop_motor_reg;

`ifndef SYNTHESIS
    // A held item must not be overwritten while the result side is stalled.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("input accepted while pipeline is stalled");

    a_stop_only_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg != ept_pkg::OP_CAPTURE) |=> !stop_motor_reg)
        else $error("stop_motor raised by a non-capture transaction");

    a_period_only_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg != ept_pkg::OP_QUERY) |=> (period_reg == 32'd0))
        else $error("nonzero period on a non-query transaction");

    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result valid without a transaction moving forward");
`endif

endmodule
